// File: rtl/drgb_pkg.sv
// ----------------------------------------------------------------------------
// drgb_pkg
// Types and constants shared by the decimal RGB triple parser and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package drgb_pkg;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_PREFIX = 3'd1,
      PH_LEAD   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_TRAIL  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FORMAT = 2'd1,
      ST_RANGE  = 2'd2,
      ST_COMMA  = 2'd3
   } status_type;

   typedef struct packed {
      logic       start_line;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [23:0] color_word;
   } rsp_type;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [8:0] MAX_COMPONENT = 9'd255;
   localparam logic [8:0] ACC_SATURATED = 9'd256;

   localparam logic [1:0] COMP_RED   = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_BLUE  = 2'd2;

endpackage

`default_nettype wire

// File: rtl/decimal_rgb_triple_parser.sv
// Latency: a result is shown on rsp_item the cycle after its closing character
// is accepted. Throughput: one character per cycle; the parse state is updated
// by one short step of logic per character. req_stall rises only while a
// result waits in the output register and rsp_stall holds it.
// Reset (synchronous, active high) returns the parser to idle and empties the
// output register.
// ----------------------------------------------------------------------------
// decimal_rgb_triple_parser
// Parses "XX r, g, b" colour lines one character per item into a packed
// 24-bit colour or an error status.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_rgb_triple_parser (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  drgb_pkg::req_type req_item,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output drgb_pkg::rsp_type rsp_item
);

   drgb_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          comp_ff, comp_in;
   logic [8:0]          acc_ff, acc_in;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;
   logic                rsp_valid_ff;
   drgb_pkg::rsp_type   rsp_ff, rsp_in;

   logic        accept;
   logic        emit;
   logic [7:0]  ch;
   logic        is_digit, is_space, is_comma, is_term;
   logic [3:0]  digit_val;
   logic [11:0] acc_wide;
   logic [8:0]  acc_step;
   logic        acc_over;
   logic        finish_emit;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign ch        = req_item.char_in;
   assign is_digit  = (ch >= drgb_pkg::CHAR_ZERO) && (ch <= drgb_pkg::CHAR_NINE);
   assign is_space  = (ch == drgb_pkg::CHAR_SPACE);
   assign is_comma  = (ch == drgb_pkg::CHAR_COMMA);
   assign is_term   = is_comma || (ch == drgb_pkg::CHAR_NEWLINE) ||
                      (ch == drgb_pkg::CHAR_NUL);
   assign digit_val = 4'(ch - drgb_pkg::CHAR_ZERO);

   // acc * 10 + digit, saturated
   assign acc_wide  = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + {8'd0, digit_val};
   assign acc_step  = (acc_wide > 12'(drgb_pkg::ACC_SATURATED)) ?
                      drgb_pkg::ACC_SATURATED : acc_wide[8:0];

   assign acc_over    = acc_ff > drgb_pkg::MAX_COMPONENT;
   assign finish_emit = acc_over || (comp_ff == drgb_pkg::COMP_BLUE) || !is_comma;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (req_item.start_line) begin
         phase_in = drgb_pkg::PH_PREFIX;
      end else begin
         unique case (phase_ff)
            drgb_pkg::PH_PREFIX: phase_in = drgb_pkg::PH_LEAD;
            drgb_pkg::PH_LEAD: begin
               if (is_digit) begin
                  phase_in = drgb_pkg::PH_DIGITS;
               end else if (!is_space) begin
                  phase_in = drgb_pkg::PH_IDLE;
               end
            end
            drgb_pkg::PH_DIGITS: begin
               priority if (is_digit) begin
                  phase_in = drgb_pkg::PH_DIGITS;
               end else if (is_space) begin
                  phase_in = drgb_pkg::PH_TRAIL;
               end else if (is_term && !finish_emit) begin
                  phase_in = drgb_pkg::PH_LEAD;
               end else begin
                  phase_in = drgb_pkg::PH_IDLE;
               end
            end
            drgb_pkg::PH_TRAIL: begin
               priority if (is_space) begin
                  phase_in = drgb_pkg::PH_TRAIL;
               end else if (is_term && !finish_emit) begin
                  phase_in = drgb_pkg::PH_LEAD;
               end else begin
                  phase_in = drgb_pkg::PH_IDLE;
               end
            end
            default: phase_in = drgb_pkg::PH_IDLE;
         endcase
      end
   end

   // data path and result
   always_comb begin
      comp_in           = comp_ff;
      acc_in            = acc_ff;
      red_in            = red_ff;
      green_in          = green_ff;
      emit              = 1'b0;
      rsp_in.status     = drgb_pkg::ST_OK;
      rsp_in.color_word = 24'd0;
      if (req_item.start_line) begin
         comp_in  = drgb_pkg::COMP_RED;
         acc_in   = 9'd0;
         red_in   = 8'd0;
         green_in = 8'd0;
      end else begin
         unique case (phase_ff)
            drgb_pkg::PH_LEAD: begin
               if (is_digit) begin
                  acc_in = {5'd0, digit_val};
               end else if (!is_space) begin
                  emit          = 1'b1;
                  rsp_in.status = drgb_pkg::ST_FORMAT;
               end
            end
            drgb_pkg::PH_DIGITS, drgb_pkg::PH_TRAIL: begin
               priority if (is_digit && phase_ff == drgb_pkg::PH_DIGITS) begin
                  acc_in = acc_step;
               end else if (is_space) begin
                  acc_in = acc_ff;
               end else if (!is_term) begin
                  emit          = 1'b1;
                  rsp_in.status = drgb_pkg::ST_FORMAT;
               end else if (acc_over) begin
                  emit          = 1'b1;
                  rsp_in.status = drgb_pkg::ST_RANGE;
               end else if (comp_ff == drgb_pkg::COMP_BLUE) begin
                  emit              = 1'b1;
                  rsp_in.color_word = {red_ff, green_ff, acc_ff[7:0]};
               end else if (!is_comma) begin
                  emit          = 1'b1;
                  rsp_in.status = drgb_pkg::ST_COMMA;
               end else begin
                  if (comp_ff == drgb_pkg::COMP_RED) begin
                     red_in = acc_ff[7:0];
                  end else begin
                     green_in = acc_ff[7:0];
                  end
                  comp_in = comp_ff + 2'd1;
                  acc_in  = 9'd0;
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= drgb_pkg::PH_IDLE;
         comp_ff      <= drgb_pkg::COMP_RED;
         acc_ff       <= 9'd0;
         red_ff       <= 8'd0;
         green_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            comp_ff  <= comp_in;
            acc_ff   <= acc_in;
            red_ff   <= red_in;
            green_ff <= green_in;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/drgb_checker.sv
// ----------------------------------------------------------------------------
// drgb_checker
// Port-level assertions for the decimal RGB triple parser.
// ----------------------------------------------------------------------------
`default_nettype none

module drgb_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input drgb_pkg::req_type req_item,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input drgb_pkg::rsp_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free output");

   a_error_color_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != drgb_pkg::ST_OK |-> rsp_item.color_word == 24'd0)
      else $error("error result carries a color");

   a_start_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_item.start_line && (!rsp_valid || !rsp_stall)
      |=> !rsp_valid)
      else $error("start character produced a result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind decimal_rgb_triple_parser drgb_checker u_drgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decimal RGB triple parser. A short table of
// colour lines covers restart, sign, range, missing comma and a good line.
// Randomly built lines with spaces, large values, bad characters and cut-off
// lines follow. Both sides idle at random. Expected results come from the
// table or a parse predictor; each is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int RUN_LIMIT   = 200000;
   localparam int PHASE_ITEMS = 417;

   typedef struct packed {
      logic                 start_line;
      logic [7:0]           char_in;
      logic                 typed;
      drgb_pkg::status_type status;
      logic [23:0]          color_word;
   } row_type;

   localparam row_type DIRECTED_ROWS [29] = '{
      '{1'b0, "Q",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b1, "X",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "X",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "5",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b1, drgb_pkg::CHAR_NUL,     1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, drgb_pkg::CHAR_NUL,     1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "-",                    1'b1, drgb_pkg::ST_FORMAT, 24'h0},
      '{1'b1, "A",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "B",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "2",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "5",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "6",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, drgb_pkg::CHAR_NEWLINE, 1'b1, drgb_pkg::ST_RANGE,  24'h0},
      '{1'b1, "C",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "C",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "0",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, drgb_pkg::CHAR_NUL,     1'b1, drgb_pkg::ST_COMMA,  24'h0},
      '{1'b1, 8'hFF,                  1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, 8'hFF,                  1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "2",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "5",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "5",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, drgb_pkg::CHAR_COMMA,   1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "0",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, drgb_pkg::CHAR_COMMA,   1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "2",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "5",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, "5",                    1'b0, drgb_pkg::ST_OK,     24'h0},
      '{1'b0, drgb_pkg::CHAR_NUL,     1'b1, drgb_pkg::ST_OK,     24'hFF00FF}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   drgb_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   drgb_pkg::rsp_type rsp_item;

   drgb_pkg::rsp_type color_expect_q [$];
   drgb_pkg::rsp_type oldest_color;
   int      fail_count = 0;
   int      stim_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_off_cycles = 0;
   int      cycle_count = 0;

   drgb_pkg::phase_type parse_phase = drgb_pkg::PH_IDLE;
   logic [1:0] prefix_left = 2'd0;
   logic [1:0] component_index = drgb_pkg::COMP_RED;
   logic [8:0] value_acc = 9'd0;
   logic [7:0] red_value = 8'd0;
   logic [7:0] green_value = 8'd0;

   decimal_rgb_triple_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the parse by one character; returns 1 when a color result is due.
   function automatic logic parse_color_char(input logic start_flag, input logic [7:0] ch,
                                             output drgb_pkg::rsp_type color);
      logic                 done;
      drgb_pkg::status_type verdict;
      logic [8:0]           digit;
      logic [12:0]          grown;
      logic                 is_digit;
      logic                 is_space;
      logic                 is_term;
      done = 1'b0;
      verdict = drgb_pkg::ST_OK;
      color = '0;
      digit = {1'b0, ch - drgb_pkg::CHAR_ZERO};
      is_digit = ch >= drgb_pkg::CHAR_ZERO && ch <= drgb_pkg::CHAR_NINE;
      is_space = ch == drgb_pkg::CHAR_SPACE;
      is_term = ch == drgb_pkg::CHAR_COMMA || ch == drgb_pkg::CHAR_NEWLINE ||
                ch == drgb_pkg::CHAR_NUL;
      if (start_flag) begin
         parse_phase = drgb_pkg::PH_PREFIX;
         prefix_left = 2'd1;
         component_index = drgb_pkg::COMP_RED;
         value_acc = 9'd0;
         red_value = 8'd0;
         green_value = 8'd0;
      end else begin
         case (parse_phase)
            drgb_pkg::PH_PREFIX: begin
               prefix_left = prefix_left - 2'd1;
               if (prefix_left == 2'd0) parse_phase = drgb_pkg::PH_LEAD;
            end
            drgb_pkg::PH_LEAD: begin
               if (is_digit) begin
                  value_acc = digit;
                  parse_phase = drgb_pkg::PH_DIGITS;
               end else if (!is_space) begin
                  done = 1'b1;
                  verdict = drgb_pkg::ST_FORMAT;
               end
            end
            drgb_pkg::PH_DIGITS, drgb_pkg::PH_TRAIL: begin
               if (is_digit && parse_phase == drgb_pkg::PH_DIGITS) begin
                  grown = 13'(value_acc) * 13'd10 + 13'(digit);
                  value_acc = (grown > 13'(drgb_pkg::ACC_SATURATED)) ?
                              drgb_pkg::ACC_SATURATED : grown[8:0];
               end else if (is_space) begin
                  parse_phase = drgb_pkg::PH_TRAIL;
               end else if (!is_term) begin
                  done = 1'b1;
                  verdict = drgb_pkg::ST_FORMAT;
               end else if (value_acc > drgb_pkg::MAX_COMPONENT) begin
                  done = 1'b1;
                  verdict = drgb_pkg::ST_RANGE;
               end else if (component_index != drgb_pkg::COMP_BLUE) begin
                  if (ch != drgb_pkg::CHAR_COMMA) begin
                     done = 1'b1;
                     verdict = drgb_pkg::ST_COMMA;
                  end else begin
                     if (component_index == drgb_pkg::COMP_RED) red_value = value_acc[7:0];
                     else green_value = value_acc[7:0];
                     component_index = component_index + 2'd1;
                     value_acc = 9'd0;
                     parse_phase = drgb_pkg::PH_LEAD;
                  end
               end else begin
                  done = 1'b1;
                  color.color_word = {red_value, green_value, value_acc[7:0]};
               end
            end
            default: parse_phase = drgb_pkg::PH_IDLE;
         endcase
      end
      if (done) begin
         parse_phase = drgb_pkg::PH_IDLE;
         color.status = verdict;
      end
      return done;
   endfunction

   // Offer one item from a falling edge; return at the falling edge after it is taken.
   task automatic send_char(input logic start_flag, input logic [7:0] ch,
                            input logic typed = 1'b0,
                            input drgb_pkg::rsp_type typed_color = '0);
      drgb_pkg::rsp_type color;
      logic              produced;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_item = '{start_line: start_flag, char_in: ch};
      do @(posedge clock); while (req_stall);
      if (start_flag || parse_phase != drgb_pkg::PH_IDLE) stim_count++;
      produced = parse_color_char(start_flag, ch, color);
      if (typed) color_expect_q.push_back(typed_color);
      else if (produced) color_expect_q.push_back(color);
      @(negedge clock);
   endtask

   task automatic send_spaces();
      if ($urandom_range(2) == 0)
         repeat ($urandom_range(1, 2)) send_char(1'b0, drgb_pkg::CHAR_SPACE);
   endtask

   task automatic send_line();
      int         pick;
      int         amount;
      string      digits;
      logic [7:0] term;
      send_char(1'b1, 8'($urandom_range(255)));
      send_char(1'b0, 8'($urandom_range(255)));
      for (int part = 0; part < 3; part++) begin
         send_spaces();
         pick = $urandom_range(99);
         if (pick < 4) begin
            send_char(1'b0, (pick < 2) ? "+" : "-");
            return;
         end
         if (pick < 7) begin
            send_char(1'b0, 8'($urandom_range(255)));
            return;
         end
         pick = $urandom_range(99);
         amount = (pick < 75) ? $urandom_range(255) :
                  (pick < 90) ? $urandom_range(256, 999) : $urandom_range(1000, 99999);
         digits = $sformatf("%0d", amount);
         if ($urandom_range(9) == 0) digits = {"00", digits};
         foreach (digits[i]) send_char(1'b0, digits[i]);
         send_spaces();
         pick = $urandom_range(99);
         if (pick < 4) begin
            send_char(1'b0, 8'($urandom_range(255)));
            return;
         end
         // drop the rest of the line; the next start restarts the parse
         if (pick < 7) return;
         if (part < 2)
            term = (pick < 92) ? drgb_pkg::CHAR_COMMA :
                   (pick < 96) ? drgb_pkg::CHAR_NEWLINE : drgb_pkg::CHAR_NUL;
         else
            term = (pick < 40) ? drgb_pkg::CHAR_COMMA :
                   (pick < 70) ? drgb_pkg::CHAR_NEWLINE : drgb_pkg::CHAR_NUL;
         send_char(1'b0, term);
         if (parse_phase == drgb_pkg::PH_IDLE) return;
      end
   endtask

   task automatic send_lines(input int upto);
      while (stim_count < upto) begin
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) send_char(1'b0, 8'($urandom_range(255)));
         send_line();
      end
   endtask

   task automatic drain_colors();
      req_valid = 1'b0;
      while (color_expect_q.size() != 0) @(negedge clock);
   endtask

   task automatic note_failure(input string what, input drgb_pkg::rsp_type want,
                               input drgb_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%s: expected status %0d color %06h, got status %0d color %06h",
                  what, want.status, want.color_word, got.status, got.color_word);
   endtask

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_off_cycles--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (color_expect_q.size() == 0) begin
            note_failure("unexpected result", '0, rsp_item);
         end else begin
            oldest_color = color_expect_q.pop_front();
            if (rsp_item.status !== oldest_color.status ||
                rsp_item.color_word !== oldest_color.color_word)
               note_failure("mismatch", oldest_color, rsp_item);
         end
      end
   end

   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 75;
      foreach (DIRECTED_ROWS[r])
         send_char(DIRECTED_ROWS[r].start_line, DIRECTED_ROWS[r].char_in, DIRECTED_ROWS[r].typed,
                   '{status: DIRECTED_ROWS[r].status, color_word: DIRECTED_ROWS[r].color_word});
      send_lines(PHASE_ITEMS);
      send_idle_pct = 75;
      recv_idle_pct = 16;
      send_lines(2 * PHASE_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain_colors();
      // hold the receiver off so the output fills and the input stalls
      hold_off_cycles = 300;
      send_lines(3 * PHASE_ITEMS);
      drain_colors();
      repeat (16) @(negedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
rtl/drgb_pkg.sv
rtl/decimal_rgb_triple_parser.sv
rtl/drgb_checker.sv
tb/tb.sv
